// File: design/video_ram_access_unit_defines.svh
// Assertion macros for the video RAM access unit.
`ifndef VIDEO_RAM_ACCESS_UNIT_DEFINES_SVH
`define VIDEO_RAM_ACCESS_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked outside reset
`define VRAU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every edge, reset included
`define VRAU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define VRAU_ASSERT(lbl, prop, msg)
`define VRAU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/vrau_pkg.sv
// Types and constants of the video RAM access unit.
`timescale 1ns / 1ps

package vrau_pkg;

   // Store geometry
   localparam int STORE_HALFWORDS = 49152;
   localparam int IDX_W           = $clog2(STORE_HALFWORDS);

   // Access kinds (req_tuser)
   localparam logic [2:0] MODE_CPU_READ  = 3'd0;
   localparam logic [2:0] MODE_CPU_WRITE = 3'd1;
   localparam logic [2:0] MODE_BG_FETCH  = 3'd2;
   localparam logic [2:0] MODE_OBJ_FETCH = 3'd3;
   localparam logic [2:0] MODE_RELEASE   = 3'd4;

   // Access widths
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   // Bitmap display modes start here
   localparam logic [2:0] VMODE_BITMAP_LO = 3'd3;
   localparam logic [2:0] VMODE_BITMAP_HI = 3'd5;

   // How the result is formed from the read halfword
   typedef enum logic [1:0] {
      SEL_ZERO    = 2'd0,
      SEL_HALF    = 2'd1,
      SEL_BYTE_LO = 2'd2,
      SEL_BYTE_HI = 2'd3
   } sel_type;

endpackage

// File: design/video_ram_access_unit.sv
// Video RAM access unit: halfword store with processor, background and object ports.
// Items pass through the memory read register, then the output register.
// One item per cycle unless rsp_tready stalls; one access per item to the one-port store.
// Results queue in one pipeline slot and one output register under backpressure.
// Reset clears the pipeline, the video mode and the background flag; store contents
// stay undefined until written.
`timescale 1ns / 1ps
`include "video_ram_access_unit_defines.svh"

module video_ram_access_unit (
   input  logic        clock,
   input  logic        reset,
   // Configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_wdata,   // video_mode
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // access_size[1:0], address[18:2], write_data[34:19], zero
   input  logic [2:0]  req_tuser,   // mode[2:0]
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // read_data[15:0], contention[16], zero
);

   localparam int IW = vrau_pkg::IDX_W;

   // Field unpacking
   logic [1:0]  req_size;
   logic [16:0] req_addr;
   logic [15:0] req_wdata;
   logic [2:0]  req_mode;

   assign req_size  = req_tdata[1:0];
   assign req_addr  = req_tdata[18:2];
   assign req_wdata = req_tdata[34:19];
   assign req_mode  = req_tuser;

   // State
   logic [2:0]  video_mode_ff;
   logic        bg_ff, bg_in;
   logic        s1_valid_ff, s1_valid_in;
   vrau_pkg::sel_type s1_sel_ff, s1_sel_in;
   logic        s1_cont_ff, s1_cont_in;
   logic [15:0] mem_q_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_cont_ff;

   logic req_fire;
   logic s1_advance;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         video_mode_ff <= 3'd0;
      end else if (csr_valid && csr_ready) begin
         video_mode_ff <= csr_wdata;
      end
   end

   // Address decode
   logic        vm_bitmap;   // modes 3 and up
   logic        vm_mid;      // modes 3 to 5
   logic        blanked;
   logic        obj_area;
   logic [16:0] folded;
   logic        byte_drop;
   logic [IW-1:0] port_idx;
   logic [IW-1:0] obj_idx;
   logic [IW-1:0] mem_idx;
   logic        mem_we;
   logic [15:0] mem_wdata;

   always_comb begin
      vm_bitmap = video_mode_ff >= vrau_pkg::VMODE_BITMAP_LO;
      vm_mid    = video_mode_ff inside {[vrau_pkg::VMODE_BITMAP_LO:vrau_pkg::VMODE_BITMAP_HI]};
      blanked   = vm_bitmap && (req_addr >= 17'h18000) && (req_addr < 17'h1c000);
      obj_area  = vm_bitmap ? (req_addr >= 17'h14000) : (req_addr >= 17'h10000);
      // Upper 32 KiB mirrors onto 0x10000-0x17fff
      folded    = {req_addr[16], req_addr[15] & ~req_addr[16], req_addr[14:0]};
      port_idx  = folded[16:1];
      // Object fetches address 0x10000 + (address & 0x7fff)
      obj_idx   = {2'b10, req_addr[14:1]};
      mem_idx   = (req_mode == vrau_pkg::MODE_OBJ_FETCH) ? obj_idx : port_idx;
      // Byte writes into object areas are ignored in modes 0 to 5
      byte_drop = (!vm_bitmap && folded[16]) || (vm_mid && folded[16] && folded[14]);
      mem_we    = req_fire && (req_mode == vrau_pkg::MODE_CPU_WRITE) && !blanked &&
                  ((req_size == vrau_pkg::SIZE_HALF) ||
                   (req_size == vrau_pkg::SIZE_BYTE && !byte_drop));
      mem_wdata = (req_size == vrau_pkg::SIZE_HALF) ? req_wdata
                                                    : {req_wdata[7:0], req_wdata[7:0]};
   end

   // Halfword store, one access per item
   logic [15:0] store_mem [vrau_pkg::STORE_HALFWORDS];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_idx] <= mem_wdata;
      end
      if (req_fire) begin
         mem_q_ff <= store_mem[mem_idx];
      end
   end

   // Result selection and background flag
   always_comb begin
      bg_in      = bg_ff;
      s1_sel_in  = vrau_pkg::SEL_ZERO;
      s1_cont_in = 1'b0;
      case (req_mode)
         vrau_pkg::MODE_CPU_READ: begin
            s1_cont_in = !obj_area && bg_ff;
            s1_sel_in  = blanked ? vrau_pkg::SEL_ZERO : vrau_pkg::SEL_HALF;
         end
         vrau_pkg::MODE_CPU_WRITE: begin
            s1_cont_in = !obj_area && bg_ff;
         end
         vrau_pkg::MODE_BG_FETCH: begin
            if (!obj_area) begin
               bg_in = 1'b1;
               if (blanked) begin
                  s1_sel_in = vrau_pkg::SEL_ZERO;
               end else if (req_size == vrau_pkg::SIZE_BYTE) begin
                  s1_sel_in = req_addr[0] ? vrau_pkg::SEL_BYTE_HI : vrau_pkg::SEL_BYTE_LO;
               end else begin
                  s1_sel_in = vrau_pkg::SEL_HALF;
               end
            end
         end
         vrau_pkg::MODE_OBJ_FETCH: begin
            // Low 16 KiB blanked in modes 3 to 5
            if (vm_mid && (req_addr[16:14] == 3'd0)) begin
               s1_sel_in = vrau_pkg::SEL_ZERO;
            end else begin
               s1_sel_in = req_addr[0] ? vrau_pkg::SEL_BYTE_HI : vrau_pkg::SEL_BYTE_LO;
            end
         end
         vrau_pkg::MODE_RELEASE: begin
            bg_in = 1'b0;
         end
         default: begin
            bg_in = bg_ff;
         end
      endcase
   end

   // Read stage control
   assign s1_valid_in = req_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff       <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            bg_ff <= bg_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sel_ff  <= s1_sel_in;
         s1_cont_ff <= s1_cont_in;
      end
   end

   // Output register
   always_comb begin
      case (s1_sel_ff)
         vrau_pkg::SEL_HALF:    rsp_data_in = mem_q_ff;
         vrau_pkg::SEL_BYTE_LO: rsp_data_in = {8'd0, mem_q_ff[7:0]};
         vrau_pkg::SEL_BYTE_HI: rsp_data_in = {8'd0, mem_q_ff[15:8]};
         default:               rsp_data_in = 16'd0;
      endcase
   end

   assign rsp_valid_in = s1_advance ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_cont_ff <= s1_cont_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cont_ff, rsp_data_ff};

   // Checks
   `VRAU_ASSERT(a_release_clears_bg,
      (req_fire && req_mode == vrau_pkg::MODE_RELEASE) |=> !bg_ff,
      "background flag still set after bus release")
   `VRAU_ASSERT(a_stalled_item_kept,
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_sel_ff) && $stable(s1_cont_ff)),
      "stalled read stage lost its item or data")
   `VRAU_ASSERT_ALWAYS(a_reset_empties,
      reset |=> (!s1_valid_ff && !rsp_valid_ff && !bg_ff),
      "pipeline or flag not cleared by reset")

endmodule
